### rtl/sha1_byte_stream_hasher_top_macros.svh
// ----------------------------------------------------------------------------
// sha1 byte stream hasher assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA1_BYTE_STREAM_HASHER_TOP_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SHA1BSH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SHA1BSH_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SHA1BSH_ASSERT_IMP(label, ante, cons, msg)
`define SHA1BSH_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

### rtl/sha1bsh_pkg.sv
// ----------------------------------------------------------------------------
// sha1bsh_pkg
// Shared types and constants of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bsh_pkg;

	// default depth of the front-to-back item queue
	localparam int QUEUE_DEPTH = 4;

	// operation codes
	localparam logic OP_ABSORB = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// initial chaining values
	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	// round constants
	localparam logic [31:0] K_0 = 32'h5A827999;
	localparam logic [31:0] K_1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_3 = 32'hCA62C1D6;

	// first padding byte
	localparam logic [7:0] PAD_BYTE = 8'h80;

	// input item
	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
	} item_t;

	// result item
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_t;

	// head of the item queue as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_head_t;

	// working variables of the compression
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	// round unit operands
	typedef struct packed {
		work_t       v;
		logic [6:0]  rnd;
		logic [31:0] w0;
		logic [31:0] w2;
		logic [31:0] w8;
		logic [31:0] w13;
	} round_in_t;

	// round unit results
	typedef struct packed {
		work_t       v;
		logic [31:0] w16;
	} round_out_t;

endpackage

### rtl/sha1bsh_stream_if.sv
// ----------------------------------------------------------------------------
// sha1bsh_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface sha1bsh_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### rtl/sha1_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_top
// SHA-1 over a byte stream with a queued front end and a one-round-per-cycle
// compression back end.
// ----------------------------------------------------------------------------
// Items enter a QueueDepth-entry queue at one per cycle while it has room, so
// the input side keeps moving during compressions. The back end takes one
// queued absorb per cycle while idle; every 64th byte starts a compression of
// 80 rounds on the single round unit followed by the chaining add. A finish
// pads one byte a cycle up to the next block end, pausing for any compression
// on the way (9 to 72 bytes, plus a turnaround in ST_PAD_ZERO before the eight
// length bytes), runs one or two compressions and then presents the five
// digest words one per cycle as the sink takes them, the fifth marked
// last_word. The back end takes the next message as soon as the last word
// enters the output register, so that word may still wait there while the
// next message is absorbed.
module sha1_byte_stream_hasher_top #(
	parameter int QueueDepth = sha1bsh_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	sha1bsh_stream_if.sink   item,
	sha1bsh_stream_if.source digest
);
`include "sha1_byte_stream_hasher_top_macros.svh"

	sha1bsh_pkg::queue_head_t fq;
	logic                     pop;

	// front end: accept and queue items
	sha1bsh_front #(
		.Depth (QueueDepth)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.head   (fq),
		.pop    (pop)
	);

	// back end: padding, compression and digest output
	sha1bsh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (fq),
		.pop    (pop),
		.digest (digest)
	);

	// queue head is valid next cycle after an accepted item
	`SHA1BSH_ASSERT_NXT(a_queue_holds_item, item.valid && item.ready, fq.valid, "queue lost an accepted item")

	// digest words come out in order without gaps
	`SHA1BSH_ASSERT_NXT(a_digest_next_word, digest.valid && digest.ready && !digest.payload.last_word, digest.valid && (digest.payload.word_index == 3'($past(digest.payload.word_index) + 3'd1)), "digest word sequence broken")

	// only the first word of a new digest may follow the last word directly
	`SHA1BSH_ASSERT_NXT(a_digest_ends, digest.valid && digest.ready && digest.payload.last_word, !digest.valid || (digest.payload.word_index == 3'd0), "extra digest word after last")

	// last flag marks exactly the fifth word
	`SHA1BSH_ASSERT_IMP(a_last_flag, digest.valid, digest.payload.last_word == (digest.payload.word_index == 3'd4), "last_word does not match word_index")
endmodule

### rtl/sha1bsh_front.sv
// ----------------------------------------------------------------------------
// sha1bsh_front
// Input acceptor: takes items off the input channel into a short queue.
// ----------------------------------------------------------------------------
module sha1bsh_front #(
	parameter int Depth = sha1bsh_pkg::QUEUE_DEPTH
) (
	input  logic                      clk,
	input  logic                      arst_n,
	sha1bsh_stream_if.sink            item,
	output sha1bsh_pkg::queue_head_t  head,
	input  logic                      pop
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	sha1bsh_pkg::item_t mem_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               full;
	logic               push;
	logic               take;
	sha1bsh_pkg::item_t in_item;

	// classify: clear the data byte of a finish
	always_comb begin
		in_item = item.payload;
		if (item.payload.operation == sha1bsh_pkg::OP_FINISH) begin
			in_item.data_byte = 8'h00;
		end
	end

	assign full       = (count_q == CntW'(Depth));
	assign item.ready = !full;
	assign push       = item.valid && !full;
	assign take       = pop && (count_q != '0);

	assign head.valid = (count_q != '0);
	assign head.item  = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				count_q <= count_q + 1'b1;
			end else if (take && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### rtl/sha1bsh_round.sv
// ----------------------------------------------------------------------------
// sha1bsh_round
// One SHA-1 round plus the next message schedule word.
// ----------------------------------------------------------------------------
module sha1bsh_round (
	input  sha1bsh_pkg::round_in_t  rin,
	output sha1bsh_pkg::round_out_t rout
);
	logic [31:0] fn;
	logic [31:0] kc;
	logic [31:0] rot_a;
	logic [31:0] sx;

	// round function and constant by round group
	always_comb begin
		if (rin.rnd < 7'd20) begin
			fn = (rin.v.b & rin.v.c) | (~rin.v.b & rin.v.d);
			kc = sha1bsh_pkg::K_0;
		end else if (rin.rnd < 7'd40) begin
			fn = rin.v.b ^ rin.v.c ^ rin.v.d;
			kc = sha1bsh_pkg::K_1;
		end else if (rin.rnd < 7'd60) begin
			fn = (rin.v.b & rin.v.c) | (rin.v.b & rin.v.d) | (rin.v.c & rin.v.d);
			kc = sha1bsh_pkg::K_2;
		end else begin
			fn = rin.v.b ^ rin.v.c ^ rin.v.d;
			kc = sha1bsh_pkg::K_3;
		end
	end

	// variable update
	assign rot_a    = {rin.v.a[26:0], rin.v.a[31:27]};
	assign rout.v.a = rot_a + fn + rin.v.e + kc + rin.w0;
	assign rout.v.b = rin.v.a;
	assign rout.v.c = {rin.v.b[1:0], rin.v.b[31:2]};
	assign rout.v.d = rin.v.c;
	assign rout.v.e = rin.v.d;

	// schedule word sixteen ahead
	assign sx       = rin.w13 ^ rin.w8 ^ rin.w2 ^ rin.w0;
	assign rout.w16 = {sx[30:0], sx[31]};
endmodule

### rtl/sha1bsh_back.sv
// ----------------------------------------------------------------------------
// sha1bsh_back
// Back end: block assembly, padding, compression sequencing, digest output.
// ----------------------------------------------------------------------------
module sha1bsh_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  sha1bsh_pkg::queue_head_t  head,
	output logic                      pop,
	sha1bsh_stream_if.source          digest
);
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_PAD_ZERO = 3'd1;
	localparam logic [2:0] ST_PAD_LEN  = 3'd2;
	localparam logic [2:0] ST_ROUND    = 3'd3;
	localparam logic [2:0] ST_ADD      = 3'd4;
	localparam logic [2:0] ST_OUT      = 3'd5;

	logic [2:0]   state_q;
	logic [2:0]   ret_q;
	logic [5:0]   fill_q;
	logic [60:0]  len_q;
	logic [6:0]   rnd_q;
	logic [2:0]   idx_q;
	logic [31:0]  h_q [5];
	logic         out_valid_q;
	logic [511:0] blk_q;
	logic [63:0]  bits_q;
	sha1bsh_pkg::work_t   v_q;
	sha1bsh_pkg::digest_t out_q;

	logic       shift_en;
	logic [7:0] shift_byte;
	logic       round_en;
	logic       load_bits;
	logic       load_out;
	logic       is_finish;
	sha1bsh_pkg::round_in_t  rin;
	sha1bsh_pkg::round_out_t rout;

	assign is_finish = (head.item.operation == sha1bsh_pkg::OP_FINISH);
	assign pop       = (state_q == ST_IDLE) && head.valid;
	assign round_en  = (state_q == ST_ROUND);
	assign load_bits = pop && is_finish;
	assign load_out  = (state_q == ST_OUT) && (!out_valid_q || digest.ready);

	// byte into the block buffer
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		case (state_q)
			ST_IDLE: begin
				shift_en   = head.valid;
				shift_byte = is_finish ? sha1bsh_pkg::PAD_BYTE : head.item.data_byte;
			end
			ST_PAD_ZERO: begin
				shift_en = (fill_q != 6'd56);
			end
			ST_PAD_LEN: begin
				shift_en   = 1'b1;
				shift_byte = bits_q[63:56];
			end
			default: begin
				shift_en = 1'b0;
			end
		endcase
	end

	// round unit taps into the schedule window
	assign rin.v   = v_q;
	assign rin.rnd = rnd_q;
	assign rin.w0  = blk_q[511:480];
	assign rin.w2  = blk_q[447:416];
	assign rin.w8  = blk_q[255:224];
	assign rin.w13 = blk_q[95:64];

	sha1bsh_round u_round (
		.rin  (rin),
		.rout (rout)
	);

	// block buffer, schedule window, working variables, length and output data
	always_ff @(posedge clk) begin
		if (shift_en) begin
			blk_q <= {blk_q[503:0], shift_byte};
		end else if (round_en) begin
			blk_q <= {blk_q[479:0], rout.w16};
		end
		if (shift_en && fill_q == 6'd63) begin
			v_q <= '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};
		end else if (round_en) begin
			v_q <= rout.v;
		end
		if (load_bits) begin
			bits_q <= {len_q, 3'b000};
		end else if (state_q == ST_PAD_LEN) begin
			bits_q <= {bits_q[55:0], 8'h00};
		end
		if (load_out) begin
			out_q.digest_word <= h_q[idx_q];
			out_q.word_index  <= idx_q;
			out_q.last_word   <= (idx_q == 3'd4);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			rnd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sha1bsh_pkg::H_INIT[i];
			end
		end else begin
			if (digest.ready && !load_out) begin
				out_valid_q <= 1'b0;
			end
			if (shift_en) begin
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						if (!is_finish) begin
							len_q <= len_q + 1'b1;
						end
						if (fill_q == 6'd63) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							ret_q   <= is_finish ? ST_PAD_ZERO : ST_IDLE;
						end else begin
							state_q <= is_finish ? ST_PAD_ZERO : ST_IDLE;
						end
					end
				end
				ST_PAD_ZERO: begin
					if (fill_q == 6'd56) begin
						state_q <= ST_PAD_LEN;
					end else if (fill_q == 6'd63) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						ret_q   <= ST_PAD_ZERO;
					end
				end
				ST_PAD_LEN: begin
					if (fill_q == 6'd63) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						ret_q   <= ST_OUT;
						idx_q   <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 7'd79) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					h_q[0]  <= h_q[0] + v_q.a;
					h_q[1]  <= h_q[1] + v_q.b;
					h_q[2]  <= h_q[2] + v_q.c;
					h_q[3]  <= h_q[3] + v_q.d;
					h_q[4]  <= h_q[4] + v_q.e;
					state_q <= ret_q;
				end
				ST_OUT: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q + 1'b1;
						if (idx_q == 3'd4) begin
							state_q <= ST_IDLE;
							fill_q  <= '0;
							len_q   <= '0;
							for (int i = 0; i < 5; i++) begin
								h_q[i] <= sha1bsh_pkg::H_INIT[i];
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign digest.valid   = out_valid_q;
	assign digest.payload = out_q;
endmodule

### bench/sha1_byte_stream_hasher_top_tb.sv
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_top_tb
// Streams byte messages into the SHA-1 hasher with random valid/ready gaps.
// A scoreboard predicts the five digest words of every finish and compares
// each digest transfer field by field, in order.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// scoreboard: own SHA-1 state and the digest words still due
	class sha1_digest_board;
		logic [31:0] chain [5];
		logic [7:0]  blk [64];
		logic [5:0]  fill;
		logic [60:0] msg_len;
		sha1bsh_pkg::digest_t digest_words_due [$];
		int          errors;

		function new();
			foreach (blk[i]) blk[i] = 8'h00;
			start_message();
			errors = 0;
		endfunction

		function void start_message();
			foreach (chain[i]) chain[i] = sha1bsh_pkg::H_INIT[i];
			fill = '0;
			msg_len = '0;
		endfunction

		// 80-round compression of the buffered block into the chaining words
		function void compress_block();
			logic [31:0] w [80];
			logic [31:0] a, b, c, d, e, f, k, t;
			for (int r = 0; r < 16; r++)
				w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
			for (int r = 16; r < 80; r++) begin
				t = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
				w[r] = {t[30:0], t[31]};
			end
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			e = chain[4];
			for (int r = 0; r < 80; r++) begin
				if (r < 20) begin
					f = (b & c) | (~b & d);
					k = sha1bsh_pkg::K_0;
				end else if (r < 40) begin
					f = b ^ c ^ d;
					k = sha1bsh_pkg::K_1;
				end else if (r < 60) begin
					f = (b & c) | (b & d) | (c & d);
					k = sha1bsh_pkg::K_2;
				end else begin
					f = b ^ c ^ d;
					k = sha1bsh_pkg::K_3;
				end
				t = {a[26:0], a[31:27]} + f + e + k + w[r];
				e = d;
				d = c;
				c = {b[1:0], b[31:2]};
				b = a;
				a = t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
			chain[4] += e;
		endfunction

		// padding, final compression(s) and the five digest words
		function void finish_message();
			logic [63:0] bit_len;
			sha1bsh_pkg::digest_t dw;
			int          pos;
			bit_len = {msg_len, 3'b000};
			pos = fill;
			blk[pos] = sha1bsh_pkg::PAD_BYTE;
			pos++;
			if (pos > 56) begin
				while (pos < 64) blk[pos++] = 8'h00;
				compress_block();
				pos = 0;
			end
			while (pos < 56) blk[pos++] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[56 + i] = bit_len[63 - 8*i -: 8];
			compress_block();
			for (int i = 0; i < 5; i++) begin
				dw.digest_word = chain[i];
				dw.word_index  = 3'(i);
				dw.last_word   = (i == 4);
				digest_words_due.push_back(dw);
			end
			start_message();
		endfunction

		// an accepted input transfer
		function void take_item(sha1bsh_pkg::item_t it);
			if (it.operation == sha1bsh_pkg::OP_ABSORB) begin
				blk[fill] = it.data_byte;
				fill++;
				msg_len++;
				if (fill == 0)
					compress_block();
			end else begin
				finish_message();
			end
		endfunction

		// an accepted digest transfer against the oldest word due
		function void check_digest(sha1bsh_pkg::digest_t got);
			sha1bsh_pkg::digest_t want;
			if (digest_words_due.size() == 0) begin
				$display("%0t: unexpected digest transfer, actual %08h idx %0d last %0b",
					$time, got.digest_word, got.word_index, got.last_word);
				errors++;
				return;
			end
			want = digest_words_due.pop_front();
			if (got.digest_word !== want.digest_word) begin
				$display("%0t: digest_word mismatch, expected %08h, actual %08h",
					$time, want.digest_word, got.digest_word);
				errors++;
			end
			if (got.word_index !== want.word_index) begin
				$display("%0t: word_index mismatch, expected %0d, actual %0d",
					$time, want.word_index, got.word_index);
				errors++;
			end
			if (got.last_word !== want.last_word) begin
				$display("%0t: last_word mismatch, expected %0b, actual %0b",
					$time, want.last_word, got.last_word);
				errors++;
			end
		endfunction

		function int words_due();
			return digest_words_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	sha1bsh_stream_if #(.payload_t(sha1bsh_pkg::item_t))   item_ch ();
	sha1bsh_stream_if #(.payload_t(sha1bsh_pkg::digest_t)) digest_ch ();

	sha1_byte_stream_hasher_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.digest (digest_ch)
	);

	sha1_digest_board board = new();

	int items_sent;
	int src_idle_pct;
	int snk_stall_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// known values on every input from time zero
	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		digest_ch.ready = 1'b0;
		items_sent = 0;
		src_idle_pct = 6;
		snk_stall_pct = 87;
	end

	// digest side: random ready, check every transfer
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && digest_ch.valid && digest_ch.ready)
				board.check_digest(digest_ch.payload);
			digest_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
		end
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(input logic op, input logic [7:0] value);
		sha1bsh_pkg::item_t it;
		it.operation = op;
		it.data_byte = value;
		if (items_sent < 110) begin
			src_idle_pct = 6;
			snk_stall_pct = 87;
		end else if (items_sent < 220) begin
			src_idle_pct = 87;
			snk_stall_pct = 6;
		end else begin
			src_idle_pct = 0;
			snk_stall_pct = 0;
		end
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		board.take_item(it);
		items_sent++;
	endtask

	// random message of the given length, then finish
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++)
			send_item(sha1bsh_pkg::OP_ABSORB, 8'($urandom_range(0, 255)));
		send_item(sha1bsh_pkg::OP_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// hold the input idle until every digest word due has arrived
	task automatic wait_digests_done();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (board.words_due() != 0);
	endtask

	// stimulus
	initial begin
		int boundary_len [$];
		int len;
		boundary_len = '{55, 56, 63, 64};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message, single extreme bytes, "abc", back-to-back finishes
		send_item(sha1bsh_pkg::OP_FINISH, 8'h00);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h00);
		send_item(sha1bsh_pkg::OP_FINISH, 8'hFF);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'hFF);
		send_item(sha1bsh_pkg::OP_FINISH, 8'h00);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h61);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h62);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h63);
		send_item(sha1bsh_pkg::OP_FINISH, 8'h5A);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h80);
		send_item(sha1bsh_pkg::OP_ABSORB, 8'h7F);
		send_item(sha1bsh_pkg::OP_FINISH, 8'hA5);
		send_item(sha1bsh_pkg::OP_FINISH, 8'hFF);

		// let the block drain completely once
		wait_digests_done();

		// random messages; lengths around the padding boundaries mixed in
		while (items_sent < 330 || boundary_len.size() != 0) begin
			if (boundary_len.size() != 0 && $urandom_range(0, 1) == 1)
				len = boundary_len.pop_front();
			else
				len = $urandom_range(0, 24);
			send_message(len);
		end

		wait_digests_done();
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.words_due() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2ms;
		$display("FAIL");
		$finish;
	end

endmodule
